[hdl/bvri_pkg.sv]
// shared types, codes and defaults for the bit vector rank engine
// no dependencies; imported by every module of the block except bvri_ram
`default_nettype none

package bvri_pkg;

	// fixed field widths
	localparam int INDEX_W  = 16;
	localparam int COUNT_W  = 17;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;

	// width of the reciprocal used for constant division of an index
	localparam int RECIP_W = 18;

	// command queue depth between front and back
	localparam int FIFO_DEPTH = 2;

	// default geometry
	localparam int MAX_BITS_DEF        = 65536;
	localparam int BLOCK_BITS_DEF      = 8;
	localparam int SUPERBLOCK_BITS_DEF = 256;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RANK1  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RANK0  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                bit_value;
		logic [INDEX_W-1:0]  index;
	} bvri_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} bvri_out_t;

	// queued command: the word plus its block and superblock numbers
	typedef struct packed {
		bvri_in_t           item;
		logic [INDEX_W-1:0] blk_num;
		logic [INDEX_W-1:0] sb_num;
	} bvri_cmd_t;

endpackage

`default_nettype wire

[hdl/bvri_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bvri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/bvri_front.sv]
// front end: accepts words and splits the index into block and superblock numbers
// depends on bvri_pkg
`default_nettype none

module bvri_front #(
	parameter int BLOCK_BITS      = bvri_pkg::BLOCK_BITS_DEF,
	parameter int SUPERBLOCK_BITS = bvri_pkg::SUPERBLOCK_BITS_DEF
) (
	input  wire logic                start,
	input  wire logic                full,
	input  wire bvri_pkg::bvri_in_t  cmd,
	output logic                     push,
	output bvri_pkg::bvri_cmd_t      entry
);
	import bvri_pkg::*;

	localparam int PROD_W = INDEX_W + RECIP_W;

	// division by a constant through a rounded-up reciprocal, exact for 16-bit indexes
	localparam int BLK_K = INDEX_W + $clog2(BLOCK_BITS);
	localparam int SB_K  = INDEX_W + $clog2(SUPERBLOCK_BITS);
	localparam logic [RECIP_W-1:0] BLK_RECIP =
		RECIP_W'(((64'd1 << BLK_K) + 64'(BLOCK_BITS) - 64'd1) / 64'(BLOCK_BITS));
	localparam logic [RECIP_W-1:0] SB_RECIP =
		RECIP_W'(((64'd1 << SB_K) + 64'(SUPERBLOCK_BITS) - 64'd1) / 64'(SUPERBLOCK_BITS));

	logic [PROD_W-1:0] blk_prod;
	logic [PROD_W-1:0] sb_prod;

	// accept when the queue has room
	assign push = start && !full;

	// block and superblock numbers of the queried position
	assign blk_prod = PROD_W'(cmd.index) * PROD_W'(BLK_RECIP);
	assign sb_prod  = PROD_W'(cmd.index) * PROD_W'(SB_RECIP);

	always_comb begin
		entry.item    = cmd;
		entry.blk_num = INDEX_W'(blk_prod >> BLK_K);
		entry.sb_num  = INDEX_W'(sb_prod >> SB_K);
	end

endmodule

`default_nettype wire

[hdl/bvri_cmd_fifo.sv]
// short command queue between the front and back ends
// depends on bvri_pkg
`default_nettype none

module bvri_cmd_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire bvri_pkg::bvri_cmd_t  push_data,
	input  wire logic                 pop,
	output bvri_pkg::bvri_cmd_t       head,
	output logic                      full,
	output logic                      empty
);
	import bvri_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	bvri_cmd_t        entries_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

[hdl/bvri_back.sv]
// back end: appends bits, clears the vector, keeps the rank directories and answers rank queries
// depends on bvri_pkg and bvri_ram
`default_nettype none

module bvri_back #(
	parameter int MAX_BITS        = bvri_pkg::MAX_BITS_DEF,
	parameter int BLOCK_BITS      = bvri_pkg::BLOCK_BITS_DEF,
	parameter int SUPERBLOCK_BITS = bvri_pkg::SUPERBLOCK_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bvri_pkg::bvri_cmd_t  head,
	input  wire logic                 empty,
	output logic                      pop,
	output logic                      done,
	output bvri_pkg::bvri_out_t       result
);
	import bvri_pkg::*;

	localparam int NBLK   = (MAX_BITS + BLOCK_BITS - 1) / BLOCK_BITS;
	localparam int NSB    = (MAX_BITS + SUPERBLOCK_BITS - 1) / SUPERBLOCK_BITS;
	localparam int BA_W   = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int SA_W   = (NSB > 1) ? $clog2(NSB) : 1;
	localparam int LEN_W  = $clog2(MAX_BITS + 1);
	localparam int BOFF_W = $clog2(BLOCK_BITS);
	localparam int SOFF_W = $clog2(SUPERBLOCK_BITS);
	localparam int BC_W   = $clog2(SUPERBLOCK_BITS);
	localparam int OSB_W  = $clog2(SUPERBLOCK_BITS + 1);
	localparam int PC_W   = $clog2(BLOCK_BITS + 1);
	localparam int BRAM_W = BLOCK_BITS + BC_W;

	localparam logic [INDEX_W-1:0] BLK_SZ = INDEX_W'(BLOCK_BITS);
	localparam logic [INDEX_W-1:0] SB_SZ  = INDEX_W'(SUPERBLOCK_BITS);

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_SUM} state_t;

	state_t state_q;

	// append side state
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      total_q;
	logic [OSB_W-1:0]      osb_q;
	logic [BOFF_W-1:0]     boff_q;
	logic [BA_W-1:0]       bidx_q;
	logic [SOFF_W-1:0]     soff_q;
	logic [SA_W-1:0]       sidx_q;
	logic [BLOCK_BITS-1:0] word_q;
	logic [BC_W-1:0]       bcnt_q;

	// query side registers
	logic [ACTION_W-1:0] act_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [INDEX_W-1:0]  bstart_q;
	logic [INDEX_W-1:0]  sstart_q;
	logic [COUNT_W-1:0]  base_q;
	logic [PC_W-1:0]     pop_q;

	// ram ports
	logic              blk_we;
	logic [BRAM_W-1:0] blk_wdata;
	logic [BRAM_W-1:0] blk_rdata;
	logic              sb_we;
	logic [LEN_W-1:0]  sb_rdata;
	logic              rd_en;

	// append datapath
	logic                  is_full;
	logic                  app_blk_start;
	logic                  app_sb_start;
	logic [OSB_W-1:0]      osb_base;
	logic [BC_W-1:0]       bcnt_next;
	logic [BLOCK_BITS-1:0] word_next;
	logic                  do_append;
	logic                  in_range;

	// query datapath
	logic                  use_blk;
	logic [BOFF_W-1:0]     lo;
	logic [BOFF_W-1:0]     hi;
	logic [PC_W-1:0]       popcnt;
	logic [COUNT_W-1:0]    base_next;
	logic [COUNT_W-1:0]    rank1;
	logic [COUNT_W-1:0]    rank0;

	assign pop = (state_q == S_IDLE) && !empty;

	// append bookkeeping: new block and superblock starts
	always_comb begin
		is_full       = (len_q == LEN_W'(MAX_BITS));
		app_blk_start = (boff_q == '0);
		app_sb_start  = (soff_q == '0);
		osb_base      = app_sb_start ? '0 : osb_q;
		bcnt_next     = app_blk_start ? BC_W'(osb_base) : bcnt_q;
		word_next     = app_blk_start ? '0 : word_q;
		word_next[boff_q] = head.item.bit_value;
		do_append     = pop && (head.item.action == ACT_APPEND) && !is_full;
		in_range      = 32'(head.item.index) < 32'(len_q);
	end

	assign blk_we    = do_append;
	assign blk_wdata = {bcnt_next, word_next};
	assign sb_we     = do_append && app_sb_start;
	assign rd_en     = pop && ((head.item.action == ACT_RANK1) || (head.item.action == ACT_RANK0));

	// block directory entry and bit word share one row per block
	bvri_ram #(
		.WIDTH (BRAM_W),
		.DEPTH (NBLK)
	) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (bidx_q),
		.wdata (blk_wdata),
		.re    (rd_en),
		.raddr (BA_W'(head.blk_num)),
		.rdata (blk_rdata)
	);

	// superblock directory
	bvri_ram #(
		.WIDTH (LEN_W),
		.DEPTH (NSB)
	) u_sb_ram (
		.clk   (clk),
		.we    (sb_we),
		.waddr (sidx_q),
		.wdata (total_q),
		.re    (rd_en),
		.raddr (SA_W'(head.sb_num)),
		.rdata (sb_rdata)
	);

	// partial block popcount and directory sum
	always_comb begin
		use_blk = (bstart_q >= sstart_q);
		lo      = use_blk ? '0 : BOFF_W'(sstart_q - bstart_q);
		hi      = BOFF_W'(idx_q - bstart_q);
		popcnt  = '0;
		for (int i = 0; i < BLOCK_BITS; i++) begin
			if ((BOFF_W'(i) >= lo) && (BOFF_W'(i) <= hi) && blk_rdata[i]) begin
				popcnt = PC_W'(popcnt + 1'b1);
			end
		end
		base_next = COUNT_W'(sb_rdata)
			+ (use_blk ? COUNT_W'(blk_rdata[BRAM_W-1:BLOCK_BITS]) : '0);
		rank1 = base_q + COUNT_W'(pop_q);
		rank0 = COUNT_W'(idx_q) + COUNT_W'(1) - rank1;
	end

	// sequencer, directory counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			total_q <= '0;
			osb_q   <= '0;
			boff_q  <= '0;
			bidx_q  <= '0;
			soff_q  <= '0;
			sidx_q  <= '0;
			done    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (head.item.action)
							ACT_APPEND: begin
								done <= 1'b1;
								if (is_full) begin
									result.count  <= COUNT_W'(len_q);
									result.status <= ST_FULL;
								end else begin
									len_q   <= LEN_W'(len_q + 1'b1);
									total_q <= LEN_W'(total_q + LEN_W'(head.item.bit_value));
									osb_q   <= OSB_W'(osb_base + OSB_W'(head.item.bit_value));
									word_q  <= word_next;
									bcnt_q  <= bcnt_next;
									if (boff_q == BOFF_W'(BLOCK_BITS - 1)) begin
										boff_q <= '0;
										bidx_q <= BA_W'(bidx_q + 1'b1);
									end else begin
										boff_q <= BOFF_W'(boff_q + 1'b1);
									end
									if (soff_q == SOFF_W'(SUPERBLOCK_BITS - 1)) begin
										soff_q <= '0;
										sidx_q <= SA_W'(sidx_q + 1'b1);
									end else begin
										soff_q <= SOFF_W'(soff_q + 1'b1);
									end
									result.count  <= COUNT_W'(len_q + 1'b1);
									result.status <= ST_OK;
								end
							end
							ACT_RANK1, ACT_RANK0: begin
								if (!in_range) begin
									done          <= 1'b1;
									result.count  <= '0;
									result.status <= ST_RANGE;
								end else begin
									done     <= 1'b0;
									act_q    <= head.item.action;
									idx_q    <= head.item.index;
									bstart_q <= INDEX_W'(head.blk_num * BLK_SZ);
									sstart_q <= INDEX_W'(head.sb_num * SB_SZ);
									state_q  <= S_CALC;
								end
							end
							ACT_CLEAR: begin
								len_q         <= '0;
								total_q       <= '0;
								osb_q         <= '0;
								boff_q        <= '0;
								bidx_q        <= '0;
								soff_q        <= '0;
								sidx_q        <= '0;
								done          <= 1'b1;
								result.count  <= '0;
								result.status <= ST_OK;
							end
							default: begin
								done <= 1'b0;
							end
						endcase
					end else begin
						done <= 1'b0;
					end
				end
				S_CALC: begin
					done    <= 1'b0;
					base_q  <= base_next;
					pop_q   <= popcnt;
					state_q <= S_SUM;
				end
				S_SUM: begin
					done          <= 1'b1;
					result.count  <= (act_q == ACT_RANK1) ? rank1 : rank0;
					result.status <= ST_OK;
					state_q       <= S_IDLE;
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/bit_vector_rank_index_core.sv]
// channel    | signals              | handshake
// -----------+----------------------+------------------------------------------
// command    | start, busy, cmd     | word taken at a clock edge with start && !busy
// result     | done, result         | one-cycle strobe, receiver cannot stall
//
// appends, clears and out-of-range queries finish in the back-end idle state; rank
// queries go through directory read, popcount and final sum; the result is registered
// and shows in the cycle after its back-end work ends
// sustained rate: one append or clear per cycle while no rank query is in progress;
// a query holds the back end until its sum is done; a two-entry queue absorbs bursts
// busy is high only while the queue is full
// reset clears length and counters; the directory and bit rams need no clearing pass
//
// top level of the rank engine; depends on bvri_pkg, bvri_front, bvri_cmd_fifo,
// bvri_back and bvri_ram
`default_nettype none

module bit_vector_rank_index_core #(
	parameter int MAX_BITS        = bvri_pkg::MAX_BITS_DEF,
	parameter int BLOCK_BITS      = bvri_pkg::BLOCK_BITS_DEF,
	parameter int SUPERBLOCK_BITS = bvri_pkg::SUPERBLOCK_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire bvri_pkg::bvri_in_t  cmd,
	output logic                     done,
	output bvri_pkg::bvri_out_t      result
);
	import bvri_pkg::*;

	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	bvri_cmd_t entry;
	bvri_cmd_t head;

	assign busy = full;

	// front end
	bvri_front #(
		.BLOCK_BITS      (BLOCK_BITS),
		.SUPERBLOCK_BITS (SUPERBLOCK_BITS)
	) u_front (
		.start (start),
		.full  (full),
		.cmd   (cmd),
		.push  (push),
		.entry (entry)
	);

	// command queue
	bvri_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	// back end
	bvri_back #(
		.MAX_BITS        (MAX_BITS),
		.BLOCK_BITS      (BLOCK_BITS),
		.SUPERBLOCK_BITS (SUPERBLOCK_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

[hdl/bvri_checker.sv]
// port-level checks for the rank engine, bound to the top level
// depends on bvri_pkg and bit_vector_rank_index_core
`default_nettype none

module bvri_checker #(
	parameter int MAX_BITS = bvri_pkg::MAX_BITS_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire bvri_pkg::bvri_in_t  cmd,
	input wire logic                done,
	input wire bvri_pkg::bvri_out_t result
);
	import bvri_pkg::*;

	// out-of-range query always reports a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_RANGE) |-> (result.count == '0))
		else $error("range status with nonzero count");

	// store-full status reports the full length
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_FULL) |-> (result.count == COUNT_W'(MAX_BITS)))
		else $error("full status with wrong length");

	// no result right after reset release
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("result strobe right after reset");

	// queue only fills through an accepted word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted word");

	// an offered word carries known bits
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !$isunknown(cmd))
		else $error("offered word has unknown bits");

endmodule

bind bit_vector_rank_index_core bvri_checker #(
	.MAX_BITS (MAX_BITS)
) u_bvri_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for bit_vector_rank_index_core: appends, rank queries and clears
// checked against a prefix-count predictor; depends on bvri_pkg and the core rtl
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bvri_pkg::*;

	localparam int VEC_MAX  = MAX_BITS_DEF;
	localparam int FILL_LEN = 300;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	bvri_in_t  cmd    = '0;
	logic      busy;
	logic      done;
	bvri_out_t result;

	// stimulus words waiting for the driver, expected results waiting for the monitor
	bvri_in_t  pending_words[$];
	bvri_out_t expected_words[$];

	// predictor state: ones in positions 0..p for every appended position p
	logic [COUNT_W-1:0] rank_upto [0:VEC_MAX-1];
	logic [COUNT_W-1:0] vec_len  = '0;
	logic [COUNT_W-1:0] vec_ones = '0;

	int errors    = 0;
	int gap_left  = 0;
	int burst_run = 0;
	int plan_len  = 0;

	bit_vector_rank_index_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard limit on run time
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// expected result of one accepted word, updates the predictor state
	function automatic bvri_out_t predict_word(bvri_in_t w);
		bvri_out_t          r;
		logic [COUNT_W-1:0] ones_upto;
		r = '0;
		case (w.action)
			ACT_APPEND: begin
				if (vec_len == COUNT_W'(VEC_MAX)) begin
					r.count  = vec_len;
					r.status = ST_FULL;
				end else begin
					vec_ones = vec_ones + COUNT_W'(w.bit_value);
					rank_upto[vec_len[INDEX_W-1:0]] = vec_ones;
					vec_len  = vec_len + 1'b1;
					r.count  = vec_len;
					r.status = ST_OK;
				end
			end
			ACT_RANK1, ACT_RANK0: begin
				if ({1'b0, w.index} >= vec_len) begin
					r.count  = '0;
					r.status = ST_RANGE;
				end else begin
					ones_upto = rank_upto[w.index];
					if (w.action == ACT_RANK1)
						r.count = ones_upto;
					else
						r.count = {1'b0, w.index} + 1'b1 - ones_upto;
					r.status = ST_OK;
				end
			end
			default: begin
				vec_len  = '0;
				vec_ones = '0;
				r.count  = '0;
				r.status = ST_OK;
			end
		endcase
		return r;
	endfunction

	// idle cycles after a word: mostly none, some short, a few long, with gap-free bursts
	function automatic int next_gap();
		int sel;
		if (burst_run > 0) begin
			burst_run--;
			return 0;
		end
		sel = $urandom_range(99, 0);
		if (sel < 2) begin
			burst_run = $urandom_range(200, 50);
			return 0;
		end
		if (sel < 65)
			return 0;
		if (sel < 95)
			return $urandom_range(3, 1);
		return $urandom_range(20, 4);
	endfunction

	// queue one stimulus word and track the planned vector length
	task automatic push_word(logic [ACTION_W-1:0] act, logic b, logic [INDEX_W-1:0] idx);
		bvri_in_t w;
		w.action    = act;
		w.bit_value = b;
		w.index     = idx;
		pending_words = {pending_words, w};
		if (act == ACT_APPEND && plan_len < VEC_MAX)
			plan_len++;
		else if (act == ACT_CLEAR)
			plan_len = 0;
	endtask

	function automatic logic [ACTION_W-1:0] any_rank();
		return ($urandom_range(1, 0) != 0) ? ACT_RANK1 : ACT_RANK0;
	endfunction

	// rank query inside the loaded vector, biased toward the last bit and block edges
	task automatic push_valid_query();
		int sel;
		int idx;
		sel = $urandom_range(3, 0);
		if (sel == 0)
			idx = plan_len - 1;
		else if (sel == 1)
			idx = ($urandom_range(plan_len - 1, 0) / 8) * 8;
		else
			idx = $urandom_range(plan_len - 1, 0);
		push_word(any_rank(), 1'($urandom_range(1, 0)), INDEX_W'(idx));
	endtask

	// driver: launch words from the pending queue, hold while busy
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left <= 0;
		end else if (!(start && busy)) begin
			if (start)
				expected_words = {expected_words, predict_word(cmd)};
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (pending_words.size() != 0) begin
				cmd      <= pending_words.pop_front();
				start    <= 1'b1;
				gap_left <= next_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		bvri_out_t exp_w;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: count %0d status %0d",
						result.count, result.status);
			end else begin
				exp_w = expected_words.pop_front();
				if (result.count !== exp_w.count || result.status !== exp_w.status) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected count %0d status %0d, got count %0d status %0d",
							exp_w.count, exp_w.status, result.count, result.status);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int density;
		int fill_mode;
		int sel;
		int idx;

		// directed: empty vector, block edge, out-of-range, clear
		push_word(ACT_CLEAR, 1'b0, 16'd0);
		push_word(ACT_RANK1, 1'b0, 16'd0);
		push_word(ACT_RANK0, 1'b1, 16'hFFFF);
		for (int k = 0; k < 12; k++)
			push_word(ACT_APPEND, 1'((k % 3) != 1), 16'hFFFF);
		push_word(ACT_RANK1, 1'b0, 16'd0);
		push_word(ACT_RANK1, 1'b0, 16'd7);
		push_word(ACT_RANK1, 1'b0, 16'd8);
		push_word(ACT_RANK0, 1'b0, 16'd11);
		push_word(ACT_RANK1, 1'b1, 16'd11);
		push_word(ACT_RANK1, 1'b0, 16'd12);
		push_word(ACT_RANK0, 1'b0, 16'd12);
		push_word(ACT_CLEAR, 1'b1, 16'hFFFF);
		push_word(ACT_RANK1, 1'b0, 16'd0);

		// random: short and long vectors, well-formed queries plus some noise
		density = 50;
		for (int k = 0; k < 650; k++) begin
			sel = $urandom_range(99, 0);
			if (sel < 1) begin
				push_word(ACT_CLEAR, 1'($urandom_range(1, 0)), INDEX_W'($urandom()));
				density = $urandom_range(100, 0);
			end else if (sel < 50) begin
				push_word(ACT_APPEND, 1'($urandom_range(99, 0) < density),
					INDEX_W'($urandom()));
			end else if (sel < 90 && plan_len != 0) begin
				push_valid_query();
			end else begin
				idx = (sel % 2 != 0) ? plan_len : $urandom_range(65535, 0);
				push_word(any_rank(), 1'($urandom_range(1, 0)), INDEX_W'(idx));
			end
		end

		// grow a vector past a superblock edge, stretches of all ones, all zeros or mixed
		push_word(ACT_CLEAR, 1'b0, 16'd0);
		fill_mode = 2;
		for (int p = 0; p < FILL_LEN; p++) begin
			if (p % 64 == 0) begin
				fill_mode = $urandom_range(3, 0);
				density   = $urandom_range(100, 0);
			end
			case (fill_mode)
				0: push_word(ACT_APPEND, 1'b0, INDEX_W'($urandom()));
				1: push_word(ACT_APPEND, 1'b1, INDEX_W'($urandom()));
				default: push_word(ACT_APPEND, 1'($urandom_range(99, 0) < density),
					INDEX_W'($urandom()));
			endcase
			if (p % 50 == 49) begin
				push_valid_query();
				push_valid_query();
			end
		end

		// two more appends, then queries over the full index range
		push_word(ACT_APPEND, 1'b1, 16'd0);
		push_word(ACT_APPEND, 1'b0, 16'hFFFF);
		push_word(ACT_RANK1, 1'b0, 16'hFFFF);
		push_word(ACT_RANK0, 1'b1, 16'hFFFF);
		push_word(ACT_RANK1, 1'b0, 16'd0);
		for (int k = 0; k < 20; k++) begin
			if ($urandom_range(3, 0) == 0)
				push_valid_query();
			else
				push_word(any_rank(), 1'($urandom_range(1, 0)),
					INDEX_W'($urandom_range(65535, 0)));
		end

		// clear after a long vector, stale tables must not show
		push_word(ACT_CLEAR, 1'b0, 16'd0);
		push_word(ACT_RANK1, 1'b0, 16'hFFFF);
		push_word(ACT_RANK0, 1'b0, 16'd0);
		push_word(ACT_APPEND, 1'b0, 16'd0);
		push_word(ACT_RANK0, 1'b0, 16'd0);
		push_word(ACT_RANK1, 1'b1, 16'd0);

		// wait for all words taken and all results back, then drain
		@(posedge arst_n);
		while (pending_words.size() != 0 || start || expected_words.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (errors == 0 && expected_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
